// File: design/isodir_pkg.sv
package isodir_pkg;

  // Record layout, counted from the size byte at offset zero.
  localparam int unsigned MinRecord = 34;
  localparam int unsigned NameStart = 33;
  localparam int unsigned NameLenAt = 32;
  localparam int unsigned FlagsAt   = 25;
  localparam int unsigned SectorAt  = 2;
  localparam int unsigned LengthAt  = 10;

  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharUnder = 8'h5F;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;

  // Result queue between the parser and the output port.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // Packed width of the output tdata, rounded up to whole bytes.
  localparam int unsigned OutDataBits = 8 + 32 + 32 + 8 + 8 + 2;
  localparam int unsigned OutDataW    = ((OutDataBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KindChar  = 2'd0,
    KindEntry = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrTooSmall = 2'd0,
    ErrOverrun  = 2'd1,
    ErrPastEnd  = 2'd2
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  name_char;
    logic [31:0] extent_sector;
    logic [31:0] extent_bytes;
    logic [7:0]  entry_flags;
    logic [7:0]  name_length;
    err_e        error_code;
    logic        last_of_run;
  } result_t;

  // Up to two results produced by one table byte.
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// File: design/isodir_parser.sv
module isodir_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  output isodir_pkg::push_t   push_o
);
  import isodir_pkg::*;

  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhGap   = 2'd1,
    PhRec   = 2'd2,
    PhErr   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  offset_q, offset_d;
  logic [7:0]  size_q, size_d;
  logic [7:0]  raw_len_q, raw_len_d;
  logic [7:0]  trim_q, trim_d;
  logic        ended_q, ended_d;
  logic [31:0] sector_q, sector_d;
  logic [31:0] length_q, length_d;
  logic [7:0]  flags_q, flags_d;

  result_t     slot_a, slot_b;
  logic        a_vld, b_vld;
  logic [7:0]  off;
  logic [7:0]  sec_rel, len_rel, name_rel;
  logic [8:0]  need;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CharUnder) begin
      r = CharDash;
    end else if (c >= CharLowA && c <= CharLowZ) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  always_comb begin
    phase_d   = phase_q;
    offset_d  = offset_q;
    size_d    = size_q;
    raw_len_d = raw_len_q;
    trim_d    = trim_q;
    ended_d   = ended_q;
    sector_d  = sector_q;
    length_d  = length_q;
    flags_d   = flags_q;
    slot_a    = '0;
    slot_b    = '0;
    a_vld     = 1'b0;
    b_vld     = 1'b0;
    off       = offset_q + 8'd1;
    sec_rel   = off - 8'(SectorAt);
    len_rel   = off - 8'(LengthAt);
    name_rel  = off - 8'(NameStart);
    need      = {1'b0, byte_i} + 9'(NameStart);

    unique case (phase_q)
      PhStart, PhGap: begin
        if (!(phase_q == PhGap && byte_i == 8'd0)) begin
          offset_d  = '0;
          raw_len_d = '0;
          trim_d    = '0;
          ended_d   = 1'b0;
          sector_d  = '0;
          length_d  = '0;
          flags_d   = '0;
          size_d    = byte_i;
          if (byte_i < 8'(MinRecord)) begin
            a_vld             = 1'b1;
            slot_a.kind       = KindError;
            slot_a.error_code = ErrTooSmall;
            phase_d           = PhErr;
          end else begin
            phase_d = PhRec;
          end
        end
      end
      PhRec: begin
        offset_d = off;
        if (sec_rel < 8'd4) begin
          sector_d[{sec_rel[1:0], 3'b000} +: 8] = byte_i;
        end
        if (len_rel < 8'd4) begin
          length_d[{len_rel[1:0], 3'b000} +: 8] = byte_i;
        end
        if (off == 8'(FlagsAt)) begin
          flags_d = byte_i;
        end
        if (off == 8'(NameLenAt)) begin
          raw_len_d = byte_i;
          if (need > {1'b0, size_q}) begin
            a_vld             = 1'b1;
            slot_a.kind       = KindError;
            slot_a.error_code = ErrOverrun;
            phase_d           = PhErr;
          end
        end
        // The name runs from offset 33 for the raw length, cut at the semicolon.
        if (phase_d == PhRec && off >= 8'(NameStart) && name_rel < raw_len_q && !ended_q) begin
          if (byte_i == CharSemi) begin
            ended_d = 1'b1;
          end else begin
            a_vld            = 1'b1;
            slot_a.kind      = KindChar;
            slot_a.name_char = fold_char(byte_i);
            trim_d           = trim_q + 8'd1;
          end
        end
        if (phase_d == PhRec && ({1'b0, off} + 9'd1) == {1'b0, size_q}) begin
          b_vld                = 1'b1;
          slot_b.kind          = KindEntry;
          slot_b.extent_sector = sector_d;
          slot_b.extent_bytes  = length_d;
          slot_b.entry_flags   = flags_d;
          slot_b.name_length   = trim_d;
          phase_d              = PhGap;
        end
      end
      PhErr: begin
      end
      default: begin
      end
    endcase

    if (end_i) begin
      if (phase_d == PhRec) begin
        b_vld             = 1'b1;
        slot_b            = '0;
        slot_b.kind       = KindError;
        slot_b.error_code = ErrPastEnd;
      end
      phase_d   = PhStart;
      offset_d  = '0;
      size_d    = '0;
      raw_len_d = '0;
      trim_d    = '0;
      ended_d   = 1'b0;
      sector_d  = '0;
      length_d  = '0;
      flags_d   = '0;
    end

    // Pack the results in order and mark the final one of this byte.
    push_o = '0;
    if (a_vld) begin
      push_o.res0             = slot_a;
      push_o.res0.last_of_run = !b_vld;
      push_o.res1             = slot_b;
      push_o.res1.last_of_run = 1'b1;
      push_o.num              = b_vld ? 2'd2 : 2'd1;
    end else if (b_vld) begin
      push_o.res0             = slot_b;
      push_o.res0.last_of_run = 1'b1;
      push_o.num              = 2'd1;
    end
    if (!fire_i) begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhStart;
      offset_q  <= '0;
      size_q    <= '0;
      raw_len_q <= '0;
      trim_q    <= '0;
      ended_q   <= 1'b0;
      sector_q  <= '0;
      length_q  <= '0;
      flags_q   <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      offset_q  <= offset_d;
      size_q    <= size_d;
      raw_len_q <= raw_len_d;
      trim_q    <= trim_d;
      ended_q   <= ended_d;
      sector_q  <= sector_d;
      length_q  <= length_d;
      flags_q   <= flags_d;
    end
  end

endmodule

// File: design/isodir_out_fifo.sv
module isodir_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isodir_pkg::push_t   push_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output isodir_pkg::result_t data_o
);
  import isodir_pkg::*;

  result_t         mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_nx;

  assign pop       = valid_o && ready_i;
  assign valid_o   = (count_q != '0);
  assign data_o    = mem_q[rd_ptr_q];
  // Room for the two results that a single byte can cause.
  assign room_o    = (count_q <= CntW'(FifoDepth - 2));
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

endmodule

// File: design/iso9660_directory_record_parser_core.sv
// ISO 9660 directory record parser. The directory table streams in one byte
// per word on the slave side, with tlast on the final byte of the table. Each
// record yields its normalised name characters (cut at the semicolon, letters
// in upper case, underscore turned into a dash) followed by one entry word
// carrying the sector, the data length, the flag byte and the trimmed name
// length; tuser tells these apart from error words. A record size below 34, a
// name that overruns its record and a table that ends inside a record each
// give one error word, after which bytes are dropped until the end of the
// table. Every byte is parsed in the cycle it is accepted, so the block takes
// one byte per clock as long as the output keeps up. A byte can cause two
// result words (a final name character together with the entry, or with the
// end-of-table error); those leave the output port one after another. A
// four-word result queue sits between the parser and the master port, and
// the slave side is ready whenever that queue has room for two words, so a
// stall on the output is absorbed without losing a byte.
module iso9660_directory_record_parser_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Table byte stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] table_byte
  input  logic                            s_axis_tlast_i,  // table_end
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] name_char, [39:8] extent_sector, [71:40] extent_bytes,
  // [79:72] entry_flags, [87:80] name_length, [89:88] error_code, rest zero
  output logic [isodir_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [1:0]                      m_axis_tuser_o,  // [1:0] kind
  output logic                            m_axis_tlast_o   // last_of_run
);
  import isodir_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    fire;

  assign s_axis_tready_o = room;
  assign fire            = s_axis_tvalid_i && room;

  isodir_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata_i),
    .end_i  (s_axis_tlast_i),
    .push_o (push)
  );

  isodir_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (head)
  );

  // The result fields are packed from the lowest bit up, zero filled on top.
  assign m_axis_tdata_o = OutDataW'({head.error_code, head.name_length, head.entry_flags,
                                     head.extent_bytes, head.extent_sector, head.name_char});
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last_of_run;

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import isodir_pkg::*;

  localparam int RandomItems = 1850;
  localparam int SettleCycles = 40;

  // Parser position inside the table, mirrored by the predictor.
  typedef enum logic [1:0] {
    TblStart  = 2'd0,
    TblGap    = 2'd1,
    TblRecord = 2'd2,
    TblSkip   = 2'd3
  } scan_e;

  // One table byte to send. A row with typed set carries its expected error
  // word directly; hold makes the sender wait until every result is back.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    err_e       err;
    logic       hold;
  } table_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  table_item_t stim_q[$];
  result_t     awaited[$];
  int          mismatches = 0;
  bit          hold_next = 1'b0;

  // Predictor state.
  scan_e       scan = TblStart;
  logic [7:0]  rec_off = '0;
  logic [7:0]  rec_size = '0;
  logic [7:0]  raw_len = '0;
  logic [7:0]  kept_len = '0;
  logic        name_done = 1'b0;
  logic [31:0] sector_acc = '0;
  logic [31:0] length_acc = '0;
  logic [7:0]  flags_acc = '0;

  // Hand-written expectations for the short directed opening. Rows without
  // typed set still go through the predictor.
  table_item_t directed_rows [11] = '{
    '{8'h00, 1'b0, 1'b1, ErrTooSmall, 1'b0},  // zero size at table start
    '{8'hFF, 1'b0, 1'b0, ErrTooSmall, 1'b0},  // dropped after the error
    '{8'h00, 1'b1, 1'b0, ErrTooSmall, 1'b0},  // end of table while dropping
    '{8'd33, 1'b1, 1'b1, ErrTooSmall, 1'b0},  // size byte is table end, too small
    '{8'd34, 1'b1, 1'b1, ErrPastEnd,  1'b0},  // size byte is table end, legal size
    '{8'hFF, 1'b1, 1'b1, ErrPastEnd,  1'b0},
    '{8'hFF, 1'b0, 1'b0, ErrTooSmall, 1'b0},  // largest record starts
    '{8'h5A, 1'b0, 1'b0, ErrTooSmall, 1'b0},
    '{8'hA5, 1'b1, 1'b1, ErrPastEnd,  1'b0},  // table ends inside the record
    '{8'h01, 1'b0, 1'b1, ErrTooSmall, 1'b0},
    '{8'h80, 1'b1, 1'b0, ErrTooSmall, 1'b0}
  };

  iso9660_directory_record_parser_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic result_t blank_word(kind_e k);
    result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic void clear_record();
    rec_off    = '0;
    rec_size   = '0;
    raw_len    = '0;
    kept_len   = '0;
    name_done  = 1'b0;
    sector_acc = '0;
    length_acc = '0;
    flags_acc  = '0;
  endfunction

  // Advances the predictor by one table byte and queues the result words it
  // yields, flagging the last one of the byte.
  function automatic void parse_table_byte(logic [7:0] b, logic fin);
    result_t w;
    int      first;
    int      off;
    first = awaited.size();
    if (scan == TblStart || scan == TblGap) begin
      // Zero bytes between records are padding; anything else is a size.
      if (!(scan == TblGap && b == 8'h00)) begin
        clear_record();
        rec_size = b;
        if (b < MinRecord) begin
          w = blank_word(KindError);
          w.error_code = ErrTooSmall;
          awaited.insert(awaited.size(), w);
          scan = TblSkip;
        end else begin
          scan = TblRecord;
        end
      end
    end else if (scan == TblRecord) begin
      rec_off = rec_off + 8'd1;
      off = int'(rec_off);
      if (off >= SectorAt && off < SectorAt + 4)
        sector_acc[8*(off-SectorAt) +: 8] = b;
      if (off >= LengthAt && off < LengthAt + 4)
        length_acc[8*(off-LengthAt) +: 8] = b;
      if (off == FlagsAt)
        flags_acc = b;
      if (off == NameLenAt) begin
        raw_len = b;
        if (int'(b) + NameStart > int'(rec_size)) begin
          w = blank_word(KindError);
          w.error_code = ErrOverrun;
          awaited.insert(awaited.size(), w);
          scan = TblSkip;
        end
      end
      if (scan == TblRecord && off >= NameStart && off - NameStart < int'(raw_len) &&
          !name_done) begin
        if (b == CharSemi) begin
          name_done = 1'b1;
        end else begin
          w = blank_word(KindChar);
          if (b == CharUnder) w.name_char = CharDash;
          else if (b >= CharLowA && b <= CharLowZ) w.name_char = b - 8'h20;
          else w.name_char = b;
          awaited.insert(awaited.size(), w);
          kept_len = kept_len + 8'd1;
        end
      end
      if (scan == TblRecord && off + 1 == int'(rec_size)) begin
        w = blank_word(KindEntry);
        w.extent_sector = sector_acc;
        w.extent_bytes  = length_acc;
        w.entry_flags   = flags_acc;
        w.name_length   = kept_len;
        awaited.insert(awaited.size(), w);
        scan = TblGap;
      end
    end
    if (fin) begin
      if (scan == TblRecord) begin
        w = blank_word(KindError);
        w.error_code = ErrPastEnd;
        awaited.insert(awaited.size(), w);
      end
      scan = TblStart;
      clear_record();
    end
    if (awaited.size() > first) begin
      w = awaited.pop_back();
      w.last_of_run = 1'b1;
      awaited.insert(awaited.size(), w);
    end
  endfunction

  // Stimulus construction.

  function automatic void add_byte(logic [7:0] b, logic fin);
    table_item_t t;
    t = '0;
    t.data = b;
    t.fin = fin;
    t.hold = hold_next;
    hold_next = 1'b0;
    stim_q.insert(stim_q.size(), t);
  endfunction

  // Name characters lean on the cases the folding treats specially.
  function automatic logic [7:0] name_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return 8'($urandom_range(CharLowA, CharLowZ));
    if (pick < 50) return 8'($urandom_range(8'h41, 8'h5A));
    if (pick < 60) return CharUnder;
    if (pick < 66) return CharSemi;
    if (pick < 70) return CharDash;
    if (pick < 76) return (pick[0]) ? CharLowA - 8'd1 : CharLowZ + 8'd1;
    return 8'($urandom);
  endfunction

  // Sends offsets 0..stop of a record; fin marks the table end on the last.
  function automatic void put_record(int size, int nlen, int stop, bit fin);
    logic [7:0] b;
    for (int k = 0; k <= stop; k++) begin
      if (k == 0) b = size[7:0];
      else if (k == NameLenAt) b = nlen[7:0];
      else if (k >= NameStart && k < NameStart + nlen) b = name_byte();
      else b = 8'($urandom);
      add_byte(b, fin && k == stop);
    end
  endfunction

  function automatic void put_noise(int n);
    for (int k = 0; k < n; k++) add_byte(8'($urandom), k == n - 1);
  endfunction

  // Mostly short records so that many entries complete; now and then the
  // largest record, with the longest legal name or a random one.
  function automatic void good_dims(output int size, output int nlen);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      nlen = 222;
      size = 255;
    end else if (pick == 1) begin
      nlen = $urandom_range(0, 222);
      size = 255;
    end else begin
      nlen = $urandom_range(0, 12);
      size = ((nlen < 1) ? 34 : 33 + nlen) + $urandom_range(0, 4);
    end
  endfunction

  function automatic void build_table();
    int pick;
    int nrec;
    int size;
    int nlen;
    int pads;
    bit last;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 24) == 0) hold_next = 1'b1;
    if (pick < 70) begin
      // Well-formed table: a few records with padding between them.
      nrec = $urandom_range(1, 4);
      for (int r = 0; r < nrec; r++) begin
        last = (r == nrec - 1);
        good_dims(size, nlen);
        if (!last) pads = $urandom_range(0, 3);
        else pads = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
        put_record(size, nlen, size - 1, last && pads == 0);
        for (int p = 0; p < pads; p++) add_byte(8'h00, last && p == pads - 1);
      end
    end else if (pick < 82) begin
      // A good record followed by a cut-off record or a bad size byte.
      good_dims(size, nlen);
      put_record(size, nlen, size - 1, 1'b0);
      pads = $urandom_range(0, 2);
      for (int p = 0; p < pads; p++) add_byte(8'h00, 1'b0);
      if ($urandom_range(0, 1)) begin
        good_dims(size, nlen);
        put_record(size, nlen, $urandom_range(1, size - 2), 1'b1);
      end else begin
        add_byte(8'($urandom_range(1, MinRecord - 1)), 1'b0);
        put_noise($urandom_range(1, 4));
      end
    end else if (pick < 92) begin
      // Name length that runs past the record.
      size = $urandom_range(34, 80);
      nlen = $urandom_range(size - 32, 255);
      if ($urandom_range(0, 1)) begin
        put_record(size, nlen, NameLenAt, 1'b1);
      end else begin
        put_record(size, nlen, NameLenAt, 1'b0);
        put_noise($urandom_range(1, 6));
      end
    end else begin
      put_noise($urandom_range(1, 40));
    end
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Sender: walks the stimulus queue, idling at random between bytes, and
  // feeds the predictor with each byte as it is accepted.
  initial begin : table_feed
    table_item_t item;
    result_t     w;
    int          gap;
    int          queued;
    bit          calm;
    calm = 1'b0;
    foreach (directed_rows[i]) stim_q.insert(stim_q.size(), directed_rows[i]);
    // The random part opens with a full drain of the result stream.
    hold_next = 1'b1;
    while (stim_q.size() < $size(directed_rows) + RandomItems) build_table();
    clear_record();
    scan = TblStart;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int idx = 0; idx < stim_q.size(); idx++) begin
      item = stim_q[idx];
      if (idx % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = item.hold ? 0 : pick_wait(calm);
      if (item.hold || gap > 0) begin
        s_axis_tvalid <= 1'b0;
        if (item.hold) begin
          do @(posedge clk_i); while (awaited.size() != 0);
        end
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= item.data;
      s_axis_tlast  <= item.fin;
      do @(posedge clk_i); while (!s_axis_tready_o);

      queued = awaited.size();
      parse_table_byte(item.data, item.fin);
      if (item.typed) begin
        // The directed row states its own single error word.
        while (awaited.size() > queued) void'(awaited.pop_back());
        w = blank_word(KindError);
        w.error_code = item.err;
        w.last_of_run = 1'b1;
        awaited.insert(awaited.size(), w);
      end
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (awaited.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("iso9660_directory_record_parser_core regression: pass");
    end else begin
      $display("iso9660_directory_record_parser_core regression: fail");
    end
    $finish;
  end

  // Receiver: stalls at random before each word and compares every word
  // with the oldest expectation.
  initial begin : result_sink
    result_t want;
    int      stall;
    int      taken;
    bit      calm;
    taken = 0;
    calm = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (taken % 48 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = pick_wait(calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
      if (awaited.size() == 0) begin
        $error("result word with nothing expected: kind %0d, tdata 0x%0h",
               m_axis_tuser_o, m_axis_tdata_o);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser_o));
        check_field("name_char", 32'(want.name_char), 32'(m_axis_tdata_o[7:0]));
        check_field("extent_sector", want.extent_sector, m_axis_tdata_o[39:8]);
        check_field("extent_bytes", want.extent_bytes, m_axis_tdata_o[71:40]);
        check_field("entry_flags", 32'(want.entry_flags), 32'(m_axis_tdata_o[79:72]));
        check_field("name_length", 32'(want.name_length), 32'(m_axis_tdata_o[87:80]));
        check_field("error_code", 32'(want.error_code), 32'(m_axis_tdata_o[89:88]));
        check_field("tdata padding", 32'd0, 32'(m_axis_tdata_o[OutDataW-1:OutDataBits]));
        check_field("last_of_run", 32'(want.last_of_run), 32'(m_axis_tlast_o));
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("iso9660_directory_record_parser_core regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
design/isodir_pkg.sv
design/isodir_parser.sv
design/isodir_out_fifo.sv
design/iso9660_directory_record_parser_core.sv
verif/testbench.sv
